### hdl/ubh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ubh_pkg
// Types and codes shared by the uniform bin histogram and its testbench.
// ----------------------------------------------------------------------------
package ubh_pkg;

  localparam int SAMPLE_W = 32;
  localparam int RB_W     = 8;
  localparam int TOTAL_W  = 32;
  localparam int BCNT_W   = 9;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT  = 2'd2;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef struct packed {
    logic                       cmd;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic [RB_W-1:0]            read_bin;
  } in_item_t;

  typedef struct packed {
    logic [RB_W-1:0]    bin_index;
    logic               hit;
    logic [TOTAL_W-1:0] bin_total;
  } out_item_t;

endpackage
`default_nettype wire

### hdl/ubh_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ubh_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module ubh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### hdl/uniform_bin_histogram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uniform_bin_histogram
// Evenly spaced bin histogram over [range_low, range_high] with saturating
// counts held in one RAM; add a sample or read back one bin per beat.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  in_     | in  | in_valid/in_ready  | in_data  (cmd, sample_value, read_bin)
//  out_    | out | out_valid/out_ready| out_data (bin_index, hit, bin_total)
//  cfg_    | in  | cfg_we             | cfg_index, cfg_wdata
//
// Add inside the range: the restoring divider yields one quotient bit per cycle
// for IW = clog2(MAX_BINS) quotient bits, between the multiply and the RAM read.
// Add at the top edge, or read: prep, RAM read, then update; no divide.
// Add out of range, or with zero bins: prep, then update (no RAM access).
// After reset a clearing pass writes zero to all MAX_BINS entries, one a
// cycle; in_ready stays low during it. Config writes are taken at any time.
// A new beat is taken while a result waits; the next result waits for it.
// ----------------------------------------------------------------------------
module uniform_bin_histogram #(
  parameter int MAX_BINS = 256
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire ubh_pkg::in_item_t                  in_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output ubh_pkg::out_item_t                      out_data,
  input  wire logic                               cfg_we,
  input  wire logic [ubh_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [ubh_pkg::CFG_DAT_W-1:0]      cfg_wdata
);

  import ubh_pkg::*;

  localparam int IW   = $clog2(MAX_BINS);
  localparam int NW   = ($clog2(MAX_BINS + 1) > BCNT_W) ? $clog2(MAX_BINS + 1) : BCNT_W;
  localparam int PW   = SAMPLE_W + NW;
  localparam int CNTW = $clog2(IW + 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_PREP, S_MUL, S_LOAD, S_DIV, S_RD, S_UPD
  } state_t;

  // configuration
  logic signed [SAMPLE_W-1:0] range_low_r, range_high_r;
  logic [BCNT_W-1:0]          bin_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r  <= '0;
      range_high_r <= '0;
      bin_count_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RANGE_LOW:  range_low_r  <= $signed(cfg_wdata);
        REG_RANGE_HIGH: range_high_r <= $signed(cfg_wdata);
        REG_BIN_COUNT:  bin_count_r  <= cfg_wdata[BCNT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [NW-1:0]       bins_ext, bins_max, bins_n;
  logic [SAMPLE_W-1:0] span;

  assign bins_ext = NW'(bin_count_r);
  assign bins_max = NW'(MAX_BINS);
  assign bins_n   = (bins_ext > bins_max) ? bins_max : bins_ext;
  assign span     = SAMPLE_W'(range_high_r - range_low_r);

  // datapath registers
  state_t                 state_r;
  in_item_t               in_r;
  out_item_t              out_r;
  logic                   out_valid_r;
  logic [IW-1:0]          clr_cnt_r;
  logic [IW-1:0]          addr_r;
  logic [SAMPLE_W-1:0]    dist_r;
  logic                   miss_r;
  logic                   rd_ok_r;
  logic [PW-1:0]          prod_r;
  logic [SAMPLE_W:0]      rem_r;
  logic [IW-1:0]          low_r;
  logic [IW-1:0]          q_r;
  logic [CNTW-1:0]        cnt_r;

  logic                   ram_we, ram_re;
  logic [IW-1:0]          ram_waddr;
  logic [TOTAL_W-1:0]     ram_wdata, ram_rdata;

  // prep stage decode
  logic signed [SAMPLE_W-1:0] v;
  logic                       counted, at_top;
  logic [IW+RB_W-1:0]         rb_ext;
  logic [IW-1:0]              rd_addr, last_bin;
  logic [NW-1:0]              n_minus1;

  assign v        = $signed(in_r.sample_value);
  assign counted  = (bins_n != '0) && !(v < range_low_r) && !(v > range_high_r);
  assign at_top   = (range_low_r == range_high_r) || (v == range_high_r);
  assign rb_ext   = (IW + RB_W)'(in_r.read_bin);
  assign rd_addr  = rb_ext[IW-1:0];
  assign n_minus1 = bins_n - NW'(1);
  assign last_bin = n_minus1[IW-1:0];

  // divider step
  logic [PW-1:0]     prod_sh;
  logic [SAMPLE_W:0] trial, span_ext;
  logic              ge;
  logic [IW-1:0]     q_nxt;

  assign prod_sh  = prod_r >> IW;
  assign trial    = {rem_r[SAMPLE_W-1:0], low_r[IW-1]};
  assign span_ext = {1'b0, span};
  assign ge       = trial >= span_ext;
  assign q_nxt    = IW'({q_r, ge});

  // result formation
  logic               upd_go;
  logic [TOTAL_W-1:0] inc_total;
  logic [IW+RB_W-1:0] addr_ext;

  assign upd_go    = (state_r == S_UPD) && (!out_valid_r || out_ready);
  assign inc_total = (ram_rdata == TOTAL_MAX) ? ram_rdata : ram_rdata + TOTAL_W'(1);
  assign addr_ext  = (IW + RB_W)'(addr_r);

  always_comb begin
    ram_re    = (state_r == S_RD);
    ram_we    = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = inc_total;
    if (state_r == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = '0;
    end else if (upd_go && !miss_r && in_r.cmd == CMD_ADD) begin
      ram_we = 1'b1;
    end
  end

  ubh_ram #(
    .WIDTH (TOTAL_W),
    .DEPTH (MAX_BINS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a beat leaving while a new result loads keeps valid high
      if (out_valid_r && out_ready && !upd_go) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + IW'(1);
          if (clr_cnt_r == IW'(MAX_BINS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            in_r    <= in_data;
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          miss_r  <= (in_r.cmd == CMD_ADD) && !counted;
          rd_ok_r <= NW'(in_r.read_bin) < bins_n;
          dist_r  <= SAMPLE_W'(v - range_low_r);
          if (in_r.cmd == CMD_READ) begin
            addr_r  <= rd_addr;
            state_r <= S_RD;
          end else if (!counted) begin
            state_r <= S_UPD;
          end else if (at_top) begin
            addr_r  <= last_bin;
            state_r <= S_RD;
          end else begin
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r  <= PW'(dist_r) * PW'(bins_n);
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          // top part is below span since dist < span
          rem_r   <= prod_sh[SAMPLE_W:0];
          low_r   <= prod_r[IW-1:0];
          q_r     <= '0;
          cnt_r   <= CNTW'(IW);
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r <= ge ? trial - span_ext : trial;
          low_r <= low_r << 1;
          q_r   <= q_nxt;
          cnt_r <= cnt_r - CNTW'(1);
          if (cnt_r == CNTW'(1)) begin
            addr_r  <= q_nxt;
            state_r <= S_RD;
          end
        end
        S_RD: begin
          state_r <= S_UPD;
        end
        S_UPD: begin
          if (upd_go) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
            if (in_r.cmd == CMD_READ) begin
              out_r.bin_index <= in_r.read_bin;
              out_r.hit       <= rd_ok_r;
              out_r.bin_total <= rd_ok_r ? ram_rdata : '0;
            end else if (miss_r) begin
              out_r <= '0;
            end else begin
              out_r.bin_index <= addr_ext[RB_W-1:0];
              out_r.hit       <= 1'b1;
              out_r.bin_total <= inc_total;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // checks
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> (state_r == S_IDLE))
    else $error("beat accepted outside idle");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < span_ext))
    else $error("divider remainder not below span");

  a_we_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_CLEAR || state_r == S_UPD))
    else $error("RAM write outside clear or update");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_UPD))
    else $error("result raised without update");

endmodule
`default_nettype wire

### sim/tb_uniform_bin_histogram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_uniform_bin_histogram
// Self-checking bench for the uniform bin histogram. Add and read beats go in
// through valid/ready with random gaps and output stalls. The bench keeps its
// own range settings and bin counts, and every result beat is checked in
// order, field by field.
// ----------------------------------------------------------------------------
module tb_uniform_bin_histogram;
  import ubh_pkg::*;

  localparam int HIST_DEPTH   = 256;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 400;
  localparam int EXP_DEPTH    = 1024;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam longint S32_MAX = 64'sh7FFF_FFFF;
  localparam longint S32_MIN = -64'sh8000_0000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_wdata;

  // bench copy of the block's settings and counts
  longint             model_low;
  longint             model_high;
  int unsigned        model_bins;
  logic [TOTAL_W-1:0] bin_tally [HIST_DEPTH];

  // expected results in order; write and read counts never wrap in one run
  out_item_t expected_fifo [EXP_DEPTH];
  int        exp_wr         = 0;
  int        exp_rd         = 0;
  int        mismatch_count = 0;
  int        tx_gap_pct     = 0;
  int        rx_stall_pct   = 0;
  int        rx_hold_len    = 0;

  uniform_bin_histogram #(.MAX_BINS(HIST_DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic int unsigned bins_active();
    return (model_bins > HIST_DEPTH) ? HIST_DEPTH : model_bins;
  endfunction

  function automatic logic [31:0] q16(int whole);
    return whole <<< 16;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Bin an add or look up a read; updates the bench counts.
  function automatic out_item_t predict_bin_result(in_item_t item);
    out_item_t   res;
    longint      v;
    int unsigned n;
    int unsigned b;
    logic [63:0] q;
    res = '0;
    n = bins_active();
    if (item.cmd == CMD_ADD) begin
      v = longint'($signed(item.sample_value));
      if (n != 0 && v >= model_low && v <= model_high) begin
        if (model_low == model_high || v == model_high) begin
          b = n - 1;
        end else begin
          // exact floor((v - low) * n / (high - low)), fits in 64 bits
          q = $unsigned(v - model_low) * n / $unsigned(model_high - model_low);
          b = (q >= n) ? n - 1 : q[31:0];
        end
        if (bin_tally[b] != TOTAL_MAX) bin_tally[b] = bin_tally[b] + 1'b1;
        res.bin_index = b[RB_W-1:0];
        res.hit       = 1'b1;
        res.bin_total = bin_tally[b];
      end
    end else begin
      res.bin_index = item.read_bin;
      if (item.read_bin < n) begin
        res.hit       = 1'b1;
        res.bin_total = bin_tally[item.read_bin];
      end
    end
    return res;
  endfunction

  function automatic logic [31:0] pick_sample();
    int unsigned sel;
    longint      v;
    logic [63:0] r;
    sel = $urandom_range(0, 99);
    r = {$urandom(), $urandom()};
    v = longint'($signed($urandom()));
    if (sel < 60 && model_low <= model_high) begin
      v = model_low + longint'(r % $unsigned(model_high - model_low + 1));
    end else if (sel < 70) begin
      v = sel[0] ? model_low : model_high;
    end else if (sel < 80) begin
      v = sel[0] ? model_low - 1 : model_high + 1;
      if (v < S32_MIN || v > S32_MAX) v = model_low;
    end
    return v[31:0];
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want_v, logic [31:0] got_v);
    mismatch_count++;
    if (mismatch_count <= 50)
      $display("[%0t] %s mismatch: expected 0x%0h, got 0x%0h", $time, what, want_v, got_v);
  endtask

  // Entered and left at a falling edge.
  task automatic send_item(in_item_t item);
    if (tx_gap_pct > 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      repeat (pick_gap()) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do begin
      @(posedge clk);
    end while (in_ready !== 1'b1);
    expected_fifo[exp_wr % EXP_DEPTH] = predict_bin_result(item);
    exp_wr++;
    @(negedge clk);
  endtask

  task automatic send_add(logic [31:0] v);
    in_item_t item;
    item.cmd          = CMD_ADD;
    item.sample_value = v;
    item.read_bin     = RB_W'($urandom());
    send_item(item);
  endtask

  task automatic send_read(logic [RB_W-1:0] r);
    in_item_t item;
    item.cmd          = CMD_READ;
    item.sample_value = $urandom();
    item.read_bin     = r;
    send_item(item);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    do begin
      @(negedge clk);
    end while (exp_wr != exp_rd);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_RANGE_LOW:  model_low  = longint'($signed(data));
      REG_RANGE_HIGH: model_high = longint'($signed(data));
      REG_BIN_COUNT:  model_bins = 32'(data[BCNT_W-1:0]);
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_range(logic [31:0] lo, logic [31:0] hi, logic [31:0] bins_word);
    wait_drain();
    cfg_write(REG_RANGE_LOW, lo);
    cfg_write(REG_RANGE_HIGH, hi);
    cfg_write(REG_BIN_COUNT, bins_word);
  endtask

  // registers at reset: zero bins, so nothing counts and every read misses
  task automatic test_zero_bins();
    cfg_write(REG_SPARE, '1);
    send_read(8'd0);
    send_read(8'hFF);
    send_add(32'h0);
  endtask

  task automatic test_bin_edges();
    set_range(q16(-8), q16(8), 32'd4);
    send_add(q16(-8));
    send_add(q16(8));
    send_add(q16(-8) - 1);
    send_add(q16(8) + 1);
    send_add(32'h0);
    send_add(q16(8) - 1);
    send_add(q16(-4) - 1);
    send_read(8'd2);
    send_read(8'd3);
    send_read(8'd4);
    send_read(8'hFF);
  endtask

  task automatic test_degenerate_ranges();
    // empty range: only the one point counts, into the last bin
    set_range(q16(5), q16(5), 32'd3);
    send_add(q16(5));
    send_add(q16(5) + 1);
    send_add(q16(5) - 1);
    // inverted range holds nothing
    set_range(q16(1), q16(-1), 32'd3);
    send_add(32'h0);
    send_read(8'd0);
  endtask

  task automatic test_full_scale();
    // bin count field all ones clamps to the store depth
    set_range(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_add(32'h8000_0000);
    send_add(32'h7FFF_FFFF);
    send_add(32'h0);
    send_add(32'hFFFF_FFFF);
    send_read(8'hFF);
    wait_drain();
    cfg_write(REG_BIN_COUNT, HIST_DEPTH);
    send_read(8'hFF);
    wait_drain();
    cfg_write(REG_BIN_COUNT, 32'd1);
    send_add($urandom());
    send_read(8'd1);
  endtask

  // output held off while the input keeps offering beats
  task automatic test_output_stall();
    set_range(32'h0, q16(4), 32'd2);
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    rx_hold_len  = HOLD_CYCLES;
    for (int i = 0; i < 24; i++) begin
      if (i % 6 == 5) send_read(RB_W'(i % 2));
      else send_add(q16(1 + 2 * (i % 2)));
    end
  endtask

  task automatic test_random_phases();
    longint      a;
    longint      b;
    longint      lo;
    longint      hi;
    logic [31:0] bins_word;
    logic [31:0] last_sample;
    int unsigned n;
    int unsigned pick;
    last_sample = '0;
    for (int phase = 0; phase < 7; phase++) begin
      a = longint'($signed($urandom()));
      b = longint'($signed($urandom()));
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        lo = S32_MIN;
        hi = S32_MAX;
      end else if (pick < 5) begin
        lo = a;
        hi = a + $urandom_range(1, 1 << 20);
        if (hi > S32_MAX) hi = S32_MAX;
      end else if (pick < 7) begin
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
      end else if (pick == 7) begin
        lo = a;
        hi = a;
      end else if (pick == 8) begin
        lo = (a < b) ? b : a;
        hi = (a < b) ? a : b;
      end else begin
        lo = -longint'($urandom_range(0, 1000));
        hi = $urandom_range(0, 1000);
      end

      pick = $urandom_range(0, 19);
      bins_word = $urandom();
      if (pick == 0) bins_word[BCNT_W-1:0] = '0;
      else if (pick < 4) bins_word[BCNT_W-1:0] = BCNT_W'($urandom_range(1, 2));
      else if (pick < 8) bins_word[BCNT_W-1:0] = BCNT_W'($urandom_range(3, 16));
      else if (pick < 13) bins_word[BCNT_W-1:0] = BCNT_W'($urandom_range(17, 255));
      else if (pick < 16) bins_word[BCNT_W-1:0] = BCNT_W'(HIST_DEPTH);
      else bins_word[BCNT_W-1:0] = BCNT_W'($urandom_range(HIST_DEPTH + 1, 511));

      set_range(lo[31:0], hi[31:0], bins_word);
      cfg_write(REG_SPARE, $urandom());
      // first phase runs back to back on both sides
      tx_gap_pct   = (phase == 0) ? 0 : $urandom_range(5, 60);
      rx_stall_pct = (phase == 0) ? 0 : $urandom_range(5, 60);
      n = bins_active();

      repeat (65) begin
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
          if (n != 0 && pick < 18) send_read(RB_W'($urandom_range(0, n - 1)));
          else send_read(RB_W'($urandom()));
        end else if (pick < 33) begin
          // sample repeated from an earlier add, so the same bin is counted again
          send_add(last_sample);
        end else begin
          last_sample = pick_sample();
          send_add(last_sample);
        end
      end
    end
  endtask

  initial begin : result_sink
    int stall_left;
    out_ready  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left == 0) begin
        if (rx_hold_len > 0) begin
          stall_left  = rx_hold_len;
          rx_hold_len = 0;
        end else if (rx_stall_pct > 0 && $urandom_range(0, 99) < rx_stall_pct) begin
          stall_left = pick_gap();
        end
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (exp_wr == exp_rd) begin
        report_mismatch("unrequested beat, bin_total", '0, out_data.bin_total);
      end else begin
        want = expected_fifo[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (out_data.bin_index !== want.bin_index)
          report_mismatch("bin_index", want.bin_index, out_data.bin_index);
        if (out_data.hit !== want.hit)
          report_mismatch("hit", want.hit, out_data.hit);
        if (out_data.bin_total !== want.bin_total)
          report_mismatch("bin_total", want.bin_total, out_data.bin_total);
      end
    end
  end

  // covers the clearing pass after reset and the long output hold
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_ready === 1'b1) ||
          (out_valid === 1'b1 && out_ready === 1'b1))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    model_low  = 0;
    model_high = 0;
    model_bins = 0;
    foreach (bin_tally[i]) bin_tally[i] = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    tx_gap_pct   = 25;
    rx_stall_pct = 25;
    test_zero_bins();
    test_bin_edges();
    test_degenerate_ranges();
    test_full_scale();
    test_output_stall();
    test_random_phases();

    wait_drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && exp_wr == exp_rd) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

### files.f
hdl/ubh_pkg.sv
hdl/ubh_ram.sv
hdl/uniform_bin_histogram.sv
sim/tb_uniform_bin_histogram.sv
